FILE: src/source_text_tokenizer_defines.svh
// Assertion macros for the source text tokenizer.
// Each use names its label and property; the clock is clk and reset is arst_n.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tokenizer assertion failed");
`define STT_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tokenizer assertion failed");
`else
`define STT_ASSERT(label, prop)
`define STT_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: src/stt_pkg.sv
`timescale 1ns / 1ps
package stt_pkg;

	typedef enum logic [3:0] {
		M_IDLE, M_NUMBER, M_IDENT, M_STRING, M_EQ, M_BANG, M_LT, M_GT, M_HALT
	} mode_t;

	typedef enum logic [4:0] {
		K_EOF = 5'd0, K_NUMBER = 5'd1, K_IDENT = 5'd2, K_STRING = 5'd3,
		K_LET = 5'd4, K_IF = 5'd5, K_ELSE = 5'd6, K_WHILE = 5'd7,
		K_FUNCTION = 5'd8, K_RETURN = 5'd9, K_PRINT = 5'd10,
		K_EQUAL = 5'd11, K_EQEQ = 5'd12, K_NEQ = 5'd13, K_LT = 5'd14,
		K_LTEQ = 5'd15, K_GT = 5'd16, K_GTEQ = 5'd17, K_PLUS = 5'd18,
		K_MINUS = 5'd19, K_STAR = 5'd20, K_SLASH = 5'd21, K_LPAREN = 5'd22,
		K_RPAREN = 5'd23, K_LBRACE = 5'd24, K_RBRACE = 5'd25, K_SEMI = 5'd26,
		K_COMMA = 5'd27, K_ERROR = 5'd28
	} kind_t;

	localparam int MAX_LEXEME = 255;
	localparam int LEN_W = 8;
	localparam int KW_COUNT = 7;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [KW_COUNT-1:0] mask_t;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_GT = 8'h3E;

	// Keyword text is right-aligned: the first letter sits highest.
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'("let"), 64'("if"), 64'("else"), 64'("while"),
		64'("function"), 64'("return"), 64'("print")
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd2, 4'd4, 4'd5, 4'd8, 4'd6, 4'd5
	};

	typedef struct packed {
		logic  emit;
		kind_t kind;
		mode_t mode;
		len_t  len;
	} take_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

	function automatic len_t len_inc(input len_t len);
		return (len < LEN_W'(MAX_LEXEME)) ? len + 1'b1 : len;
	endfunction

	function automatic logic [7:0] kw_char(input int i, input logic [2:0] pos);
		int sh;
		sh = 8 * (int'(KW_LEN[i]) - 1 - int'(pos));
		if (sh < 0)
			return CH_NUL;
		return KW_TEXT[i][sh +: 8];
	endfunction

	// Drops every keyword that no longer matches after byte c at position len.
	function automatic mask_t ident_mask(input mask_t mask, input len_t len,
		input logic [7:0] c);
		mask_t m;
		m = mask;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (len >= LEN_W'(KW_LEN[i]) || kw_char(i, len[2:0]) != c)
				m[i] = 1'b0;
		end
		return m;
	endfunction

	function automatic kind_t ident_kind(input mask_t mask, input len_t len);
		kind_t k;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (mask[i] && len == LEN_W'(KW_LEN[i]))
				k = kind_t'(5'(K_LET) + 5'(i));
		end
		return k;
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		case (c)
			8'h2B: return K_PLUS;
			8'h2D: return K_MINUS;
			8'h2A: return K_STAR;
			8'h2F: return K_SLASH;
			8'h28: return K_LPAREN;
			8'h29: return K_RPAREN;
			8'h7B: return K_LBRACE;
			8'h7D: return K_RBRACE;
			8'h3B: return K_SEMI;
			8'h2C: return K_COMMA;
			default: return K_ERROR;
		endcase
	endfunction

	// Handles a byte with no token open.
	function automatic take_t idle_take(input logic [7:0] c, input len_t len);
		take_t t;
		t.emit = 1'b0;
		t.kind = K_EOF;
		t.mode = M_IDLE;
		t.len = len;
		if (c == CH_NUL) begin
			t.emit = 1'b1;
			t.len = '0;
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
			t.len = len;
		end else if (is_digit(c)) begin
			t.mode = M_NUMBER;
			t.len = LEN_W'(1);
		end else if (is_word(c)) begin
			t.mode = M_IDENT;
			t.len = LEN_W'(1);
		end else if (c == CH_QUOTE) begin
			t.mode = M_STRING;
			t.len = '0;
		end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
			t.mode = (c == CH_EQ) ? M_EQ : (c == CH_BANG) ? M_BANG :
				(c == CH_LT) ? M_LT : M_GT;
			t.len = LEN_W'(1);
		end else begin
			t.emit = 1'b1;
			t.kind = single_kind(c);
			if (t.kind == K_ERROR) begin
				t.mode = M_HALT;
				t.len = '0;
			end else begin
				t.len = LEN_W'(1);
			end
		end
		return t;
	endfunction

endpackage

FILE: src/source_text_tokenizer.sv
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"
// Source text tokenizer: takes one byte of text per word on the input side (byte 0 ends the
// text) and gives the kind of each token on the output side. It takes one byte per clock
// cycle while in_stall is low. A number, an identifier or a one-byte '=', '<' or '>' is
// reported only when the byte after it arrives. If a byte closes one token and is itself a
// one-byte token or the end of text, it gives two result words. Results leave through a
// four-word queue at one word per cycle while out_stall is low. The first word for a byte
// can be taken in the cycle after that byte is accepted. The input stalls while the queue
// holds more than two words. After a lone '!' or an unknown byte the block reports an
// error word. It then takes and drops all further bytes until reset.
module source_text_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          ch,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          kind
);
	import stt_pkg::*;

	mode_t  mode_q, nx_mode;
	mask_t  mask_q, nx_mask;
	len_t   len_q, nx_len;
	take_t  tk;
	logic   emit_a, use_take, in_acc, out_acc;
	kind_t  kind_a, k0, k1;
	logic [1:0] n_push, n_res;

	kind_t            fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_stall = cnt_q > CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign kind = 5'(fifo_q[rd_q]);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_comb begin
		tk = idle_take(ch, len_q);
		emit_a = 1'b0;
		kind_a = K_EOF;
		use_take = 1'b0;
		nx_mode = mode_q;
		nx_mask = mask_q;
		nx_len = len_q;
		unique case (mode_q) inside
			M_HALT: begin
				nx_mode = M_HALT;
			end
			M_NUMBER: begin
				if (is_digit(ch)) begin
					nx_len = len_inc(len_q);
				end else begin
					emit_a = 1'b1;
					kind_a = K_NUMBER;
					use_take = 1'b1;
				end
			end
			M_IDENT: begin
				if (is_word(ch)) begin
					nx_mask = ident_mask(mask_q, len_q, ch);
					nx_len = len_inc(len_q);
				end else begin
					emit_a = 1'b1;
					kind_a = ident_kind(mask_q, len_q);
					use_take = 1'b1;
				end
			end
			M_STRING: begin
				if (ch == CH_QUOTE) begin
					emit_a = 1'b1;
					kind_a = K_STRING;
					nx_mode = M_IDLE;
				end else if (ch == CH_NUL) begin
					emit_a = 1'b1;
					kind_a = K_STRING;
					use_take = 1'b1;
				end else begin
					nx_len = len_inc(len_q);
				end
			end
			M_EQ, M_BANG, M_LT, M_GT: begin
				emit_a = 1'b1;
				if (ch == CH_EQ) begin
					kind_a = (mode_q == M_EQ) ? K_EQEQ : (mode_q == M_BANG) ? K_NEQ :
						(mode_q == M_LT) ? K_LTEQ : K_GTEQ;
					nx_len = len_inc(len_q);
					nx_mode = M_IDLE;
				end else if (mode_q == M_BANG) begin
					kind_a = K_ERROR;
					nx_mode = M_HALT;
				end else begin
					kind_a = (mode_q == M_EQ) ? K_EQUAL : (mode_q == M_LT) ? K_LT : K_GT;
					use_take = 1'b1;
				end
			end
			default: begin
				use_take = 1'b1;
			end
		endcase
		if (use_take) begin
			nx_mode = tk.mode;
			nx_len = tk.len;
			// A fresh identifier starts with every keyword still possible.
			if (tk.mode == M_IDENT)
				nx_mask = ident_mask('1, '0, ch);
		end
		// The closing word of an open token always goes out ahead of the new one.
		if (emit_a) begin
			k0 = kind_a;
			k1 = tk.kind;
			n_res = (use_take && tk.emit) ? 2'd2 : 2'd1;
		end else begin
			k0 = tk.kind;
			k1 = tk.kind;
			n_res = (use_take && tk.emit) ? 2'd1 : 2'd0;
		end
		n_push = in_acc ? n_res : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			mask_q <= '1;
			len_q <= '0;
		end else if (in_acc) begin
			mode_q <= nx_mode;
			mask_q <= nx_mask;
			len_q <= nx_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + PTR_W'(n_push);
			rd_q <= rd_q + PTR_W'(out_acc);
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(out_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			fifo_q[wr_q] <= k0;
		if (n_push == 2'd2)
			fifo_q[wr_q + PTR_W'(1)] <= k1;
	end

	`STT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(FIFO_DEPTH))
	`STT_ASSERT_NEXT(a_halt_sticky, mode_q == M_HALT, mode_q == M_HALT)
	`STT_ASSERT(a_halt_silent, (mode_q == M_HALT) |-> (n_push == 2'd0))
	`STT_ASSERT_NEXT(a_cnt_pop, (n_push == 2'd0) && out_acc, cnt_q == $past(cnt_q) - 1'b1)

endmodule
